[src/wcsp_pkg.sv]
// Package: opcodes, status codes and shared types for the sample profiler.
package wcsp_pkg;

    localparam int OPCODE_W = 3;
    localparam int CTX_ID_W = 4;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W    = 32;
    localparam int MS_W     = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK   = 3'd0,
        OP_REG    = 3'd1,
        OP_DEREG  = 3'd2,
        OP_ENTER  = 3'd3,
        OP_EXIT   = 3'd4,
        OP_QUERY  = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_NONE   = 3'd7
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_ZERO    = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [MS_W-1:0]  MS_MAX  = '1;

    // controller to datapath
    typedef struct packed {
        logic start;     // latch item, do the item's direct work
        logic roll;      // one rollover step
        logic clr;       // one clear step
        logic qacc;      // one query accumulate step
        logic dstep;     // one divider step
        logic dinit;     // set up divider
        logic done;      // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_roll;
        logic need_clr;
        logic need_query;
        logic last;      // sweep or divide counter at its end
    } t_stat;

endpackage

[src/wcsp_if.sv]
// Interfaces: item channels and the configuration write channel.
interface wcsp_in_if;
    import wcsp_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CTX_ID_W-1:0] context_id;
    modport source(output valid, opcode, context_id, input ready);
    modport sink(input valid, opcode, context_id, output ready);
endinterface

interface wcsp_out_if;
    import wcsp_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    modport source(output valid, status, value, input ready);
    modport sink(input valid, status, value, output ready);
endinterface

interface wcsp_cfg_if;
    import wcsp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[src/windowed_context_sample_profiler.sv]
// Top level: windowed context sample profiler.
//  channel  | dir | payload
//  in_ch    | in  | opcode[3], context_id[4]
//  out_ch   | out | status[2], value[7]
//  cfg_ch   | in  | index[2], data[16]
// A simple item passes through execute and done; rollover adds a sweep over the
// CONTEXTS current counts and clear a sweep over all CONTEXTS*HISTORY_WINDOWS history rows;
// a query adds an accumulate pass over the history windows and a bit-serial divide.
// After reset a clearing pass over all history rows runs before the first item.
// One item at a time; input ready drops while a result waits to be taken.
module windowed_context_sample_profiler #(
    parameter int CONTEXTS = 16,
    parameter int HISTORY_WINDOWS = 3
) (
    input logic i_clk,
    input logic i_rst_n,
    wcsp_in_if.sink    in_ch,
    wcsp_out_if.source out_ch,
    wcsp_cfg_if.sink   cfg_ch
);
    import wcsp_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign in_ch.ready  = in_ready;
    assign cfg_ch.ready = 1'b1;

    wcsp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .o_in_ready(in_ready), .i_out_busy(out_ch.valid),
        .i_stat(stat), .o_cmd(cmd)
    );

    wcsp_dp #(.CONTEXTS(CONTEXTS), .HISTORY_WINDOWS(HISTORY_WINDOWS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_opcode(in_ch.opcode), .i_context_id(in_ch.context_id),
        .i_cfg_we(cfg_ch.valid), .i_cfg_idx(cfg_ch.index), .i_cfg_data(cfg_ch.data),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .o_status(out_ch.status), .o_value(out_ch.value)
    );
endmodule

[src/wcsp_ctrl.sv]
// Controller: sequences item work, rollover, clear, query and division.
module wcsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_busy,
    input  wcsp_pkg::t_stat i_stat,
    output wcsp_pkg::t_cmd  o_cmd
);
    import wcsp_pkg::*;

    typedef enum logic [7:0] {
        S_INIT  = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_EXEC  = 8'b00000100,
        S_ROLL  = 8'b00001000,
        S_CLR   = 8'b00010000,
        S_QACC  = 8'b00100000,
        S_DIV   = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE) && !i_out_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr = 1'b1;
                if (i_stat.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.need_roll) n_state = S_ROLL;
                else if (i_stat.need_clr) n_state = S_CLR;
                else if (i_stat.need_query) n_state = S_QACC;
                else n_state = S_DONE;
            end
            S_ROLL: begin
                o_cmd.roll = 1'b1;
                if (i_stat.last) n_state = S_DONE;
            end
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.last) n_state = S_DONE;
            end
            S_QACC: begin
                o_cmd.qacc = 1'b1;
                if (i_stat.last) begin
                    o_cmd.dinit = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
                if (i_stat.last) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else r_state <= n_state;
    end

`ifndef ASSERT_OFF
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_start_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_EXEC)
        else $error("start did not lead to exec");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("done did not return to idle");
`endif
endmodule

[src/wcsp_dp.sv]
// Datapath: counters, context and history memories, query sums and divider.
module wcsp_dp #(
    parameter int CONTEXTS = 16,
    parameter int HISTORY_WINDOWS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wcsp_pkg::t_cmd                i_cmd,
    output wcsp_pkg::t_stat               o_stat,
    input  logic [wcsp_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [wcsp_pkg::CTX_ID_W-1:0] i_context_id,
    input  logic                          i_cfg_we,
    input  logic [wcsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wcsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [wcsp_pkg::STATUS_W-1:0] o_status,
    output logic [wcsp_pkg::VALUE_W-1:0]  o_value
);
    import wcsp_pkg::*;

    localparam int CW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int HW = (HISTORY_WINDOWS > 1) ? $clog2(HISTORY_WINDOWS) : 1;
    localparam int HD = CONTEXTS * HISTORY_WINDOWS;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int SW = CNT_W + 4 + 7;  // sum width, numerator with *100
    localparam int NW = SW;
    localparam int DW = $clog2(NW + 1);
    localparam int KW = HAW + 1;        // sweep counter, holds max count
    localparam logic [HW-1:0] HLAST = HW'(HISTORY_WINDOWS - 1);
    localparam logic [CW-1:0] CLAST = CW'(CONTEXTS - 1);

    // configuration
    logic            r_enable;
    logic [MS_W-1:0] r_period, r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_period <= MS_W'(1);
            r_window <= MS_W'(300);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_WINDOW: r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories: current counts and history counts (row = ctx*HISTORY_WINDOWS + slot)
    logic [CNT_W-1:0] m_cur [CONTEXTS];
    logic [CNT_W-1:0] m_hist [HD];
    logic [CONTEXTS-1:0] r_present, r_has_hist;
    logic [CNT_W-1:0] r_tot_hist [HISTORY_WINDOWS];
    logic [CNT_W-1:0] r_tot_cur;
    logic [HW-1:0]    r_slot;
    logic [CW-1:0]    r_gen;
    logic             r_act_v;
    logic [CW-1:0]    r_act;
    logic [MS_W-1:0]  r_since_s, r_since_w;

    logic [CTX_ID_W-1:0] r_id;
    logic r_need_roll, r_need_clr, r_need_query;
    logic [KW-1:0] r_k;
    logic [STATUS_W-1:0] r_st;
    logic [VALUE_W-1:0]  r_val;
    logic [SW-1:0] r_part, r_whole;
    logic [NW-1:0] r_num, r_rem_q;
    logic [SW:0]   r_rem;
    logic [DW-1:0] r_dcnt;
    logic [CNT_W-1:0] r_hist_rd;

    logic id_ok;
    logic [CW-1:0] idc;
    assign id_ok = 32'(i_context_id) < 32'(CONTEXTS);
    assign idc   = CW'(i_context_id);

    logic [MS_W-1:0] ns_s, ns_w;
    logic samp;
    assign ns_s = (r_since_s != MS_MAX) ? r_since_s + MS_W'(1) : r_since_s;
    assign ns_w = (r_since_w != MS_MAX) ? r_since_w + MS_W'(1) : r_since_w;
    assign samp = r_enable && (ns_s >= r_period);

    // active context count, zero when it holds no entry
    logic [CNT_W-1:0] cur_act;
    assign cur_act = r_present[r_act] ? m_cur[r_act] : '0;

    logic [CW-1:0] kc;
    logic [HW-1:0] kh;
    assign kc = CW'(r_k);
    assign kh = HW'(r_k);

    logic [HAW-1:0] qaddr, raddr;
    assign qaddr = HAW'(32'(CW'(r_id)) * HISTORY_WINDOWS + 32'(kh));
    assign raddr = HAW'(32'(kc) * HISTORY_WINDOWS + 32'(r_slot));

    logic sweep_last;
    always_comb begin
        sweep_last = 1'b0;
        if (i_cmd.roll) sweep_last = (kc == CLAST);
        else if (i_cmd.clr) sweep_last = (r_k == KW'(HD - 1));
        else if (i_cmd.qacc) sweep_last = (r_k == KW'(HISTORY_WINDOWS));
        else if (i_cmd.dstep) sweep_last = (r_dcnt == DW'(1));
    end
    assign o_stat = '{need_roll: r_need_roll, need_clr: r_need_clr,
                      need_query: r_need_query, last: sweep_last};

    // query: accumulate one window per cycle (read data is registered, so it arrives in the cycle after its address)
    logic [SW-1:0] part_n, whole_n;
    logic [SW:0]   trial;
    logic [NW-1:0] q_fin;
    assign part_n  = (r_k != '0) ? r_part + SW'(r_hist_rd) : r_part;
    assign whole_n = (r_k != '0) ? r_whole + SW'(r_tot_hist[HW'(r_k - KW'(1))]) : r_whole;
    assign trial = {r_rem[SW-1:0], r_num[NW-1]} - {1'b0, r_whole};
    assign q_fin = {r_rem_q[NW-2:0], ~trial[SW]};

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            unique case (t_opcode'(i_opcode))
                OP_REG:   m_cur[r_gen] <= '0;
                OP_DEREG: if (id_ok) m_cur[idc] <= '0;
                OP_TICK:  if (samp && r_act_v)
                    m_cur[r_act] <= (cur_act != CNT_MAX) ? cur_act + CNT_W'(1) : cur_act;
                default: ;
            endcase
        end
        if (i_cmd.roll) m_hist[raddr] <= r_present[kc] ? m_cur[kc] : '0;
        if (i_cmd.clr) begin
            m_hist[HAW'(r_k)] <= '0;
            if (r_k < KW'(CONTEXTS)) m_cur[kc] <= '0;
        end
        r_hist_rd <= m_hist[qaddr];
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0; r_has_hist <= '0; r_tot_cur <= '0; r_slot <= '0;
            r_gen <= '0; r_act_v <= 1'b0; r_act <= '0; r_since_s <= '0;
            r_since_w <= '0; r_need_roll <= 1'b0; r_need_clr <= 1'b1;
            r_need_query <= 1'b0; r_k <= '0; o_out_valid <= 1'b0;
            for (int h = 0; h < HISTORY_WINDOWS; h++) r_tot_hist[h] <= '0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (i_cmd.start) begin
                r_id <= i_context_id; r_k <= '0;
                r_st <= ST_OK; r_val <= '0;
                r_need_roll <= 1'b0; r_need_clr <= 1'b0; r_need_query <= 1'b0;
                unique case (t_opcode'(i_opcode))
                    OP_TICK: begin
                        r_since_s <= ns_s; r_since_w <= ns_w;
                        if (samp) begin
                            r_since_s <= '0;
                            if (!r_act_v) r_st <= ST_UNKNOWN;
                            else begin
                                r_present[r_act] <= 1'b1;
                                if (r_tot_cur != CNT_MAX) r_tot_cur <= r_tot_cur + CNT_W'(1);
                                if (ns_w >= r_window) begin
                                    r_need_roll <= 1'b1; r_since_w <= '0;
                                end
                            end
                        end
                    end
                    OP_REG: begin
                        r_present[r_gen] <= 1'b1;
                        r_val <= VALUE_W'(r_gen);
                        r_gen <= (r_gen == CLAST) ? '0 : r_gen + CW'(1);
                    end
                    OP_DEREG: if (!id_ok) r_st <= ST_UNKNOWN;
                              else r_present[idc] <= 1'b0;
                    OP_ENTER: if (!id_ok) r_st <= ST_UNKNOWN;
                              else if (r_enable) begin
                                  r_act_v <= 1'b1; r_act <= idc;
                              end
                    OP_EXIT: begin r_act_v <= 1'b0; r_act <= '0; end
                    OP_QUERY: if (!id_ok) r_st <= ST_UNKNOWN;
                              else if (!r_has_hist[idc]) r_st <= ST_UNKNOWN;
                              else r_need_query <= 1'b1;
                    OP_CLEAR: begin
                        r_need_clr <= 1'b1; r_present <= '0; r_has_hist <= '0;
                        r_tot_cur <= '0; r_slot <= '0; r_gen <= '0; r_act_v <= 1'b0;
                        r_act <= '0; r_since_s <= '0; r_since_w <= '0;
                        for (int h = 0; h < HISTORY_WINDOWS; h++) r_tot_hist[h] <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.roll) begin
                r_k <= r_k + KW'(1);
                if (r_present[kc]) r_has_hist[kc] <= 1'b1;
                r_present[kc] <= 1'b0;
                if (kc == CLAST) begin
                    r_tot_hist[r_slot] <= r_tot_cur;
                    r_tot_cur <= '0;
                    r_slot <= (r_slot == HLAST) ? '0 : r_slot + HW'(1);
                    r_need_roll <= 1'b0;
                end
            end
            if (i_cmd.clr) begin
                r_k <= r_k + KW'(1);
                if (r_k == KW'(HD - 1)) r_need_clr <= 1'b0;
            end
            if (i_cmd.qacc) r_k <= r_k + KW'(1);
            if (i_cmd.dinit && whole_n == '0) r_st <= ST_ZERO;
            if (i_cmd.dstep && r_dcnt == DW'(1) && r_st == ST_OK)
                r_val <= (q_fin > NW'(100)) ? VALUE_W'(100) : VALUE_W'(q_fin);
            if (i_cmd.done) begin
                o_out_valid <= 1'b1; o_status <= r_st; o_value <= r_val;
                r_need_query <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_part <= '0; r_whole <= '0;
        end
        if (i_cmd.qacc) begin
            r_part <= part_n; r_whole <= whole_n;
        end
        if (i_cmd.dinit) begin
            r_num   <= NW'(part_n * SW'(100));
            r_rem   <= '0;
            r_rem_q <= '0;
            r_dcnt  <= DW'(NW);
        end
        if (i_cmd.dstep) begin
            r_dcnt  <= r_dcnt - DW'(1);
            r_num   <= {r_num[NW-2:0], 1'b0};
            r_rem_q <= q_fin;
            if (!trial[SW]) r_rem <= trial;
            else r_rem <= {r_rem[SW-1:0], r_num[NW-1]};
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped");
    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_value <= VALUE_W'(100))
        else $error("value out of range");
    a_roll_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < HISTORY_WINDOWS)
        else $error("history slot out of range");
`endif
endmodule
